/* rtl/ffre_pkg.sv */
// Shared types, constants and helper functions for the frame flip and rotate engine.
package ffre_pkg;

    // Largest frame held in the store.
    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

    // Derived widths.
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int POS_W   = $clog2(MAX_DIM);
    localparam int CMP_W   = DIM_W + 1;
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int PIX_W   = 24;
    localparam int CFG_W   = 8;
    localparam int CIDX_W  = 2;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_TRANSFORM    = 2'd2;

    // Transform codes.
    localparam logic [1:0] XF_IDENTITY = 2'd0;
    localparam logic [1:0] XF_MIRROR_H = 2'd1;
    localparam logic [1:0] XF_MIRROR_V = 2'd2;
    localparam logic [1:0] XF_ROTATE   = 2'd3;

    // Request modes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 8'd128;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 8'd128;

    // Input request.
    typedef struct packed {
        logic       mode;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    // Output result.
    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last_pixel;
        logic       not_ready;
    } t_pix_out;

    // Command passed from the front to the back through the queue.
    typedef struct packed {
        logic              is_load;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
        logic              last;
        logic              err;
    } t_cmd;

    // Clamp a register dimension into 1..max.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int max);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (int'(v) > max) begin
            res = DIM_W'(max);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

    // Store address of a pixel; row and column are held inside the store.
    function automatic logic [ADDR_W-1:0] store_addr(input logic [POS_W-1:0] row,
                                                     input logic [POS_W-1:0] col);
        logic [POS_W-1:0] r;
        logic [POS_W-1:0] c;
        r = (int'(row) >= MAX_HEIGHT) ? POS_W'(MAX_HEIGHT - 1) : row;
        c = (int'(col) >= MAX_WIDTH) ? POS_W'(MAX_WIDTH - 1) : col;
        return ADDR_W'(r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
    endfunction

endpackage

/* rtl/frame_flip_rotate_engine_unit.sv */
// Top level of the frame flip and rotate engine.
//
// Usage: requests enter on i_in_valid / o_in_stall with payload i_req. A load
// request (mode 0) writes the next pixel of the frame in raster order and
// gives no result. A fetch request (mode 1) gives one result on o_out_valid /
// i_out_stall: the next pixel of the mirrored or rotated frame, with
// last_pixel on the final one, or zeros with not_ready if the frame is not
// yet fully loaded. Frame size and transform are written on the i_cfg_* port
// while no request is outstanding.
// Throughput is one request per cycle while the queue has room, set by the
// single port of the frame store, which each request uses at most once. A
// fetch result is registered at the store read and in the output register;
// a four-entry command queue separates the request side from the store, and
// the output register plus a skid stage keep requests flowing while a result
// waits to be taken. When the receiver stalls, results hold; once the queue
// fills, o_in_stall rises. Reset (synchronous, active low) clears all
// positions, the configuration and pending work; the frame store is not cleared.
module frame_flip_rotate_engine_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  ffre_pkg::t_pix_in           i_req,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output ffre_pkg::t_pix_out          o_rsp,
    input  logic                        i_cfg_we,
    input  logic [ffre_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [ffre_pkg::CFG_W-1:0]  i_cfg_wdata
);
    import ffre_pkg::*;

    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    t_cmd push_cmd;
    t_cmd head_cmd;

    ffre_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .i_q_full    (q_full)
    );

    ffre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    ffre_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_rsp       (o_rsp)
    );

endmodule

/* rtl/ffre_ram.sv */
// Generic single-port RAM with registered read data.
module ffre_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write or one read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ffre_front.sv */
// Front end: accepts requests, keeps load and emit positions, builds store commands.
module ffre_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ffre_pkg::t_pix_in             i_req,
    input  logic                          i_cfg_we,
    input  logic [ffre_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  logic [ffre_pkg::CFG_W-1:0]    i_cfg_wdata,
    output logic                          o_push,
    output ffre_pkg::t_cmd                o_cmd,
    input  logic                          i_q_full
);
    import ffre_pkg::*;

    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [1:0]       r_transform;
    logic [POS_W-1:0] r_load_col, n_load_col;
    logic [POS_W-1:0] r_load_row, n_load_row;
    logic [POS_W-1:0] r_emit_col, n_emit_col;
    logic [POS_W-1:0] r_emit_row, n_emit_row;
    logic             r_complete, n_complete;

    logic             accept;
    logic [DIM_W-1:0] w, h, out_w, out_h;
    logic [POS_W-1:0] lc, lr, er, ec, src_row, src_col;
    t_cmd             cmd;

    assign accept     = i_in_valid & ~i_q_full;
    assign o_in_stall = i_q_full;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_transform    <= XF_IDENTITY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                CFG_TRANSFORM:    r_transform    <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Position bookkeeping and command build for one request.
    always_comb begin
        w = clamp_dim(r_frame_width, MAX_WIDTH);
        h = clamp_dim(r_frame_height, MAX_HEIGHT);
        out_w = (r_transform == XF_ROTATE) ? h : w;
        out_h = (r_transform == XF_ROTATE) ? w : h;

        n_load_col = r_load_col;
        n_load_row = r_load_row;
        n_emit_col = r_emit_col;
        n_emit_row = r_emit_row;
        n_complete = r_complete;
        lc = r_load_col;
        lr = r_load_row;
        cmd = '0;

        // A stale emit position restarts at the first output pixel.
        er = r_emit_row;
        ec = r_emit_col;
        if (CMP_W'(er) >= CMP_W'(out_h) || CMP_W'(ec) >= CMP_W'(out_w)) begin
            er = '0;
            ec = '0;
        end

        // Source pixel of the current output position.
        case (r_transform)
            XF_MIRROR_H: begin
                src_row = er;
                src_col = POS_W'(CMP_W'(w) - CMP_W'(1) - CMP_W'(ec));
            end
            XF_MIRROR_V: begin
                src_row = POS_W'(CMP_W'(h) - CMP_W'(1) - CMP_W'(er));
                src_col = ec;
            end
            XF_ROTATE: begin
                src_row = POS_W'(CMP_W'(h) - CMP_W'(1) - CMP_W'(ec));
                src_col = er;
            end
            default: begin
                src_row = er;
                src_col = ec;
            end
        endcase

        if (accept) begin
            if (i_req.mode == MODE_LOAD) begin
                // A load after a full frame starts a new one.
                if (r_complete) begin
                    lc = '0;
                    lr = '0;
                    n_complete = 1'b0;
                end
                cmd.is_load = 1'b1;
                cmd.addr    = store_addr(lr, lc);
                cmd.pix     = {i_req.red_in, i_req.green_in, i_req.blue_in};
                n_load_col  = lc;
                n_load_row  = lr;
                if (CMP_W'(lc) + CMP_W'(1) >= CMP_W'(w)) begin
                    n_load_col = '0;
                    if (CMP_W'(lr) + CMP_W'(1) >= CMP_W'(h)) begin
                        n_load_row = '0;
                        n_complete = 1'b1;
                        n_emit_row = '0;
                        n_emit_col = '0;
                    end else begin
                        n_load_row = lr + POS_W'(1);
                    end
                end else begin
                    n_load_col = lc + POS_W'(1);
                end
            end else if (!r_complete) begin
                cmd.err = 1'b1;
            end else begin
                cmd.addr = store_addr(src_row, src_col);
                cmd.last = (CMP_W'(er) + CMP_W'(1) == CMP_W'(out_h)) &&
                           (CMP_W'(ec) + CMP_W'(1) == CMP_W'(out_w));
                if (CMP_W'(ec) + CMP_W'(1) >= CMP_W'(out_w)) begin
                    n_emit_col = '0;
                    n_emit_row = (CMP_W'(er) + CMP_W'(1) >= CMP_W'(out_h)) ? '0
                                                                           : er + POS_W'(1);
                end else begin
                    n_emit_col = ec + POS_W'(1);
                    n_emit_row = er;
                end
            end
        end
    end

    // Position registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_col <= '0;
            r_load_row <= '0;
            r_emit_col <= '0;
            r_emit_row <= '0;
            r_complete <= 1'b0;
        end else begin
            r_load_col <= n_load_col;
            r_load_row <= n_load_row;
            r_emit_col <= n_emit_col;
            r_emit_row <= n_emit_row;
            r_complete <= n_complete;
        end
    end

    assign o_push = accept;
    assign o_cmd  = cmd;

    // A complete frame always leaves the load position at the origin.
    a_complete_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_complete |-> (r_load_col == '0 && r_load_row == '0))
        else $error("load position not at origin with a complete frame");

endmodule

/* rtl/ffre_queue.sv */
// Short command queue that decouples the front end from the store access.
module ffre_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ffre_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ffre_pkg::t_cmd o_cmd
);
    import ffre_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_buf [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_cmd   = r_buf[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (int'(r_wr_ptr) == QUEUE_DEPTH - 1) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (int'(r_rd_ptr) == QUEUE_DEPTH - 1) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

endmodule

/* rtl/ffre_back.sv */
// Back end: carries out store writes and reads and holds results for the receiver.
module ffre_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  ffre_pkg::t_cmd     i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ffre_pkg::t_pix_out o_rsp
);
    import ffre_pkg::*;

    logic             r_rd_vld;
    logic             r_rd_last;
    logic             r_rd_err;
    logic             r_out_vld;
    t_pix_out         r_out;
    logic             r_skid_vld;
    t_pix_out         r_skid;

    logic             take;
    logic             room;
    logic             issue_rd;
    logic [1:0]       held;
    logic [PIX_W-1:0] rdata;
    t_pix_out         rd_rsp;

    // Pending results may not exceed the two output slots.
    assign take     = r_out_vld & ~i_out_stall;
    assign held     = 2'(r_rd_vld) + 2'(r_out_vld) + 2'(r_skid_vld) - 2'(take);
    assign room     = (held < 2'd2);
    assign o_pop    = ~i_q_empty & (i_cmd.is_load | room);
    assign issue_rd = o_pop & ~i_cmd.is_load;

    ffre_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (o_pop & i_cmd.is_load),
        .i_re    (issue_rd & ~i_cmd.err),
        .i_addr  (i_cmd.addr),
        .i_wdata (i_cmd.pix),
        .o_rdata (rdata)
    );

    // Result built from the store read; an early fetch reads as zero.
    always_comb begin
        rd_rsp            = '0;
        rd_rsp.last_pixel = r_rd_last;
        rd_rsp.not_ready  = r_rd_err;
        if (!r_rd_err) begin
            rd_rsp.red_out   = rdata[23:16];
            rd_rsp.green_out = rdata[15:8];
            rd_rsp.blue_out  = rdata[7:0];
        end
    end

    // Read in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue_rd;
        end
        if (issue_rd) begin
            r_rd_last <= i_cmd.last;
            r_rd_err  <= i_cmd.err;
        end
    end

    // Output register with a skid stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (take || !r_out_vld) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_out      <= r_skid;
                r_skid_vld <= r_rd_vld;
                r_skid     <= rd_rsp;
            end else begin
                r_out_vld <= r_rd_vld;
                r_out     <= rd_rsp;
            end
        end else if (r_rd_vld) begin
            r_skid_vld <= 1'b1;
            r_skid     <= rd_rsp;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_rsp       = r_out;

    // The skid stage only fills behind a held output.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid stage holds a result while the output register is empty");

    // No more than two results are ever pending.
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_rd_vld, r_out_vld, r_skid_vld}) <= 2)
        else $error("more results pending than output slots");

    // A read is never issued while both output slots are spoken for.
    a_no_read_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_skid_vld && i_out_stall) |-> !issue_rd)
        else $error("store read issued with no room for its result");

endmodule

/* test/frame_flip_rotate_engine_unit_tb.sv */
// Self-checking testbench for the frame flip and rotate engine with a built-in pixel predictor.
module frame_flip_rotate_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffre_pkg::*;

    localparam int  CLK_PERIOD    = 10;
    localparam int  RESET_CYCLES  = 7;
    localparam int  IDLE_PCT      = 6;
    localparam int  SETTLE_CYCLES = 16;
    localparam int  RANDOM_ITEMS  = 850;
    localparam time TIMEOUT_NS    = 5_000_000;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_pix_in            i_req       = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_pix_out           o_rsp;
    logic               i_cfg_we    = 1'b0;
    logic [CIDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_W-1:0]   i_cfg_wdata = '0;

    // Requests waiting to be sent and pixels waiting to come back.
    t_pix_in  pending_reqs[$];
    t_pix_out expected_pixels[$];
    int       unsent_reqs  = 0;
    int       error_count  = 0;
    bit       quiet_mode   = 1'b0;

    // Register copies shared by the predictor and the stimulus planner.
    logic [CFG_W-1:0] cur_width  = FRAME_WIDTH_RST;
    logic [CFG_W-1:0] cur_height = FRAME_HEIGHT_RST;
    logic [1:0]       cur_xform  = XF_IDENTITY;

    // Predictor state, advanced as requests are accepted.
    logic [PIX_W-1:0] held_pixels[DEPTH];
    int fill_col    = 0;
    int fill_row    = 0;
    bit frame_ready = 1'b0;
    int read_row    = 0;
    int read_col    = 0;

    // Planner state, advanced as requests are queued, so that no fetch ever
    // reads a store entry that was never loaded.
    bit gen_written[DEPTH];
    int gen_col   = 0;
    int gen_row   = 0;
    bit gen_ready = 1'b0;
    bit gen_safe  = 1'b0;

    frame_flip_rotate_engine_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req       (i_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // A zero dimension counts as one, an oversized one as the store limit.
    function automatic int eff_dim(input logic [CFG_W-1:0] v, input int limit);
        if (v == '0) begin
            return 1;
        end
        return (int'(v) > limit) ? limit : int'(v);
    endfunction

    // Work out the pixel a request produces and advance the predictor.
    task automatic apply_request(input t_pix_in req);
        int       w;
        int       h;
        int       out_w;
        int       out_h;
        int       src_r;
        int       src_c;
        t_pix_out rsp;
        w = eff_dim(cur_width, MAX_WIDTH);
        h = eff_dim(cur_height, MAX_HEIGHT);
        rsp = '0;
        if (req.mode == MODE_LOAD) begin
            if (frame_ready) begin
                frame_ready = 1'b0;
                fill_col    = 0;
                fill_row    = 0;
            end
            held_pixels[ADDR_W'(fill_row * MAX_WIDTH + fill_col)] =
                {req.red_in, req.green_in, req.blue_in};
            if (fill_col + 1 >= w) begin
                fill_col = 0;
                if (fill_row + 1 >= h) begin
                    fill_row    = 0;
                    frame_ready = 1'b1;
                    read_row    = 0;
                    read_col    = 0;
                end else begin
                    fill_row++;
                end
            end else begin
                fill_col++;
            end
        end else if (!frame_ready) begin
            rsp.not_ready = 1'b1;
            expected_pixels.push_back(rsp);
        end else begin
            out_w = (cur_xform == XF_ROTATE) ? h : w;
            out_h = (cur_xform == XF_ROTATE) ? w : h;
            // A register change can leave the read position outside the frame.
            if (read_row >= out_h || read_col >= out_w) begin
                read_row = 0;
                read_col = 0;
            end
            case (cur_xform)
                XF_MIRROR_H: begin
                    src_r = read_row;
                    src_c = w - 1 - read_col;
                end
                XF_MIRROR_V: begin
                    src_r = h - 1 - read_row;
                    src_c = read_col;
                end
                XF_ROTATE: begin
                    src_r = h - 1 - read_col;
                    src_c = read_row;
                end
                default: begin
                    src_r = read_row;
                    src_c = read_col;
                end
            endcase
            {rsp.red_out, rsp.green_out, rsp.blue_out} =
                held_pixels[ADDR_W'(src_r * MAX_WIDTH + src_c)];
            rsp.last_pixel = (read_row + 1 == out_h) && (read_col + 1 == out_w);
            if (read_col + 1 >= out_w) begin
                read_col = 0;
                read_row = (read_row + 1 >= out_h) ? 0 : read_row + 1;
            end else begin
                read_col++;
            end
            expected_pixels.push_back(rsp);
        end
    endtask

    // True when every pixel of the current frame area has been loaded once.
    function automatic bit region_written();
        int w;
        int h;
        w = eff_dim(cur_width, MAX_WIDTH);
        h = eff_dim(cur_height, MAX_HEIGHT);
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                if (!gen_written[ADDR_W'(r * MAX_WIDTH + c)]) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // Queue a load request and track where the frame fill stands.
    task automatic queue_load(input logic [PIX_W-1:0] rgb);
        t_pix_in item;
        int      w;
        int      h;
        w = eff_dim(cur_width, MAX_WIDTH);
        h = eff_dim(cur_height, MAX_HEIGHT);
        item.mode = MODE_LOAD;
        {item.red_in, item.green_in, item.blue_in} = rgb;
        pending_reqs.push_back(item);
        unsent_reqs++;
        if (gen_ready) begin
            gen_ready = 1'b0;
            gen_col   = 0;
            gen_row   = 0;
        end
        gen_written[ADDR_W'(gen_row * MAX_WIDTH + gen_col)] = 1'b1;
        if (gen_col + 1 >= w) begin
            gen_col = 0;
            if (gen_row + 1 >= h) begin
                gen_row   = 0;
                gen_ready = 1'b1;
                gen_safe  = region_written();
            end else begin
                gen_row++;
            end
        end else begin
            gen_col++;
        end
    endtask

    // Queue a fetch; a finished frame with holes gets a fresh load instead.
    task automatic queue_fetch();
        t_pix_in item;
        if (gen_ready && !gen_safe) begin
            queue_load(PIX_W'($urandom()));
        end else begin
            item.mode = MODE_FETCH;
            {item.red_in, item.green_in, item.blue_in} = PIX_W'($urandom());
            pending_reqs.push_back(item);
            unsent_reqs++;
        end
    endtask

    // Write one register; only called while the engine is idle.
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FRAME_WIDTH:  cur_width  = value;
            CFG_FRAME_HEIGHT: cur_height = value;
            CFG_TRANSFORM:    cur_xform  = value[1:0];
            default: ;
        endcase
        gen_safe = region_written();
    endtask

    // Hold off until every request is sent and every pixel is back, then
    // give trailing loads time to reach the store.
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (unsent_reqs != 0 || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            error_count++;
        end
    endtask

    // Request driver: present queued requests, with occasional gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                apply_request(i_req);
                unsent_reqs--;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_reqs.size() != 0 &&
                    (quiet_mode || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    i_in_valid <= 1'b1;
                    i_req      <= pending_reqs.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Pixel monitor: compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin : pixel_monitor
        t_pix_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected pixel, expected none, got %p", $time, o_rsp);
                error_count++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("red_out", want.red_out, o_rsp.red_out);
                check_field("green_out", want.green_out, o_rsp.green_out);
                check_field("blue_out", want.blue_out, o_rsp.blue_out);
                check_field("last_pixel", 8'(want.last_pixel), 8'(o_rsp.last_pixel));
                check_field("not_ready", 8'(want.not_ready), 8'(o_rsp.not_ready));
            end
        end
        i_out_stall <= !quiet_mode && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Stimulus: directed corner cases, then random phases between register changes.
    initial begin
        int random_items;
        int n;
        int area;
        int choice;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fetch with nothing loaded, then a load and a fetch mid-frame.
        queue_fetch();
        queue_load(24'hFFFFFF);
        queue_fetch();
        wait_idle();

        // Shrink to 3x2 while the first row is partly loaded; the fill continues.
        write_reg(CFG_FRAME_WIDTH, 8'd3);
        write_reg(CFG_FRAME_HEIGHT, 8'd2);
        write_reg(CFG_TRANSFORM, CFG_W'(XF_IDENTITY));
        queue_load(24'h000000);
        queue_load(24'hFF0000);
        queue_load(24'h00FF00);
        queue_load(24'h0000FF);
        queue_load(24'h5AA53C);
        // Read past the last pixel so the order wraps.
        repeat (8) queue_fetch();
        wait_idle();

        // Narrowing a finished frame leaves the read position outside; it restarts.
        write_reg(CFG_FRAME_WIDTH, 8'd2);
        write_reg(CFG_TRANSFORM, CFG_W'(XF_ROTATE));
        repeat (5) queue_fetch();
        // A load after a finished frame begins a new one.
        queue_load(24'h808080);
        queue_fetch();

        // Random phases: mostly small frames, now and then an extreme shape.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            wait_idle();
            quiet_mode = (random_items >= 300 && random_items < 500);
            choice = $urandom_range(0, 9);
            if (choice < 5) begin
                write_reg(CFG_FRAME_WIDTH, CFG_W'($urandom_range(1, 6)));
                write_reg(CFG_FRAME_HEIGHT, CFG_W'($urandom_range(1, 6)));
            end else if (choice == 5) begin
                case ($urandom_range(0, 3))
                    0: begin
                        write_reg(CFG_FRAME_WIDTH, 8'd128);
                        write_reg(CFG_FRAME_HEIGHT, 8'd1);
                    end
                    1: begin
                        write_reg(CFG_FRAME_WIDTH, 8'd1);
                        write_reg(CFG_FRAME_HEIGHT, 8'd128);
                    end
                    2: begin
                        write_reg(CFG_FRAME_WIDTH, 8'd0);
                        write_reg(CFG_FRAME_HEIGHT, 8'd255);
                    end
                    default: begin
                        write_reg(CFG_FRAME_HEIGHT, 8'd0);
                        write_reg(CFG_FRAME_WIDTH, 8'd200);
                    end
                endcase
            end else if (choice == 6) begin
                write_reg(CFG_FRAME_HEIGHT, CFG_W'($urandom_range(1, 12)));
            end
            if ($urandom_range(0, 9) < 7) begin
                write_reg(CFG_TRANSFORM, CFG_W'($urandom_range(0, 3)));
            end

            area = eff_dim(cur_width, MAX_WIDTH) * eff_dim(cur_height, MAX_HEIGHT);
            n = $urandom_range(area / 2 + 1, 2 * area + 4);
            if (n > 300) begin
                n = 300;
            end
            // Mostly whole frames followed by reads, with stray early fetches
            // and the odd reload cutting a read-out short.
            repeat (n) begin
                if (!gen_ready) begin
                    if ($urandom_range(0, 99) < 90) begin
                        queue_load(PIX_W'($urandom()));
                    end else begin
                        queue_fetch();
                    end
                end else if ($urandom_range(0, 99) < 92) begin
                    queue_fetch();
                end else begin
                    queue_load(PIX_W'($urandom()));
                end
                random_items++;
            end
        end
        quiet_mode = 1'b0;

        wait_idle();
        if (error_count == 0) begin
            $display("frame_flip_rotate_engine_unit_tb passed");
        end else begin
            $display("frame_flip_rotate_engine_unit_tb failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake or a missing pixel.
    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout, %0d requests unsent, %0d pixels outstanding",
                 $time, unsent_reqs, expected_pixels.size());
        $display("frame_flip_rotate_engine_unit_tb failed");
        $finish;
    end

endmodule
